// File: src/mpsm_pkg.sv
package mpsm_pkg;

    localparam int NODES = 1024;
    localparam int NODE_W = $clog2(NODES);
    localparam int ALPHABET = 26;
    localparam int LET_W = 5;
    localparam int COUNT_WIDTH = 16;
    localparam int MATCH_W = 16;
    localparam int TOTAL_W = 32;
    localparam int USED_W = NODE_W + 1;

    localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_END = 3'd2;
    localparam logic [2:0] REQ_BUILD = 3'd3;
    localparam logic [2:0] REQ_SCAN = 3'd4;

    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [LET_W-1:0] letter;
        logic             text_start;
    } req_t;

    typedef struct packed {
        logic [MATCH_W-1:0] match_count;
        logic [TOTAL_W-1:0] running_total;
        logic               clean;
        logic               node_overflow;
        logic [NODE_W-1:0]  current_node;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_INS,
        S_ENDW,
        S_SC1,
        S_SC2,
        S_SC3,
        S_SCF,
        S_BQ,
        S_BN,
        S_BF,
        S_BL,
        S_BC,
        S_BW,
        S_DONE
    } state_t;

endpackage

// File: src/multi_pattern_string_matcher_unit.sv
// Aho-Corasick matcher over 26 letters with one response per request transaction. The trie
// (one 1024-row memory of 26 next-node entries), the failure links, the output links and
// the end counts live in synchronous memories. After reset and after every clear request
// a clearing pass, one row per cycle, runs before a new request is taken. An insert or
// end mark reads the entry of the current node and then updates it; a scan letter follows
// the goto entry and then walks the output chain node by node; a build walks the trie
// breadth first through a queue, letter by letter per node. Each memory has a single read port.
// The response register lets the next request enter while a response still waits.
module multi_pattern_string_matcher_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mpsm_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output mpsm_pkg::rsp_t       rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    localparam int NW = mpsm_pkg::NODE_W;
    localparam int CW = mpsm_pkg::COUNT_WIDTH;

    mpsm_pkg::row_t  goto_mem [mpsm_pkg::NODES];
    logic [NW-1:0]   fail_mem [mpsm_pkg::NODES];
    logic [NW-1:0]   out_mem  [mpsm_pkg::NODES];
    logic [CW-1:0]   end_mem  [mpsm_pkg::NODES];
    logic [NW-1:0]   queue_mem[mpsm_pkg::NODES];

    mpsm_pkg::row_t  g_rdata;
    logic [NW-1:0]   f_rdata;
    logic [NW-1:0]   o_rdata;
    logic [CW-1:0]   e_rdata;
    logic [NW-1:0]   q_rdata;

    logic            g_we, g_re, f_we, f_re, o_we, o_re, e_we, e_re, q_we, q_re;
    logic [NW-1:0]   g_waddr, g_raddr, f_waddr, f_raddr, o_waddr, o_raddr;
    logic [NW-1:0]   e_waddr, e_raddr, q_waddr, q_raddr;
    mpsm_pkg::row_t  g_wdata;
    logic [NW-1:0]   f_wdata, o_wdata, q_wdata;
    logic [CW-1:0]   e_wdata;

    mpsm_pkg::state_t            state_reg, state_next;
    mpsm_pkg::req_t              req_reg, req_next;
    logic [NW-1:0]               ins_cur_reg, ins_cur_next;
    logic [NW-1:0]               scan_cur_reg, scan_cur_next;
    logic [mpsm_pkg::USED_W-1:0] used_reg, used_next;
    logic [mpsm_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        built_reg, built_next;
    logic                        consume_reg;
    logic [mpsm_pkg::MATCH_W-1:0] count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [NW-1:0]               clr_idx_reg, clr_idx_next;
    logic                        clr_rsp_reg, clr_rsp_next;
    logic [NW:0]                 head_reg, head_next, tail_reg, tail_next;
    logic [NW-1:0]               node_reg, node_next;
    mpsm_pkg::row_t              row_reg, row_next;
    logic [mpsm_pkg::LET_W-1:0]  let_reg, let_next;
    logic [NW-1:0]               j_reg, j_next;
    mpsm_pkg::rsp_t              rsp_reg, rsp_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    logic                        take;
    logic [NW-1:0]               child;
    logic [NW-1:0]               scan_eff;
    logic [mpsm_pkg::MATCH_W:0]  sum_wide;
    logic [mpsm_pkg::TOTAL_W:0]  total_wide;
    logic                        rsp_free;
    logic                        let_ok;

    assign req_ready = (state_reg == mpsm_pkg::S_IDLE);
    assign take = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
    assign child = row_reg[let_reg];
    assign scan_eff = req.text_start ? mpsm_pkg::ROOT : scan_cur_reg;
    assign sum_wide = {1'b0, count_reg} + (mpsm_pkg::MATCH_W+1)'(e_rdata);
    assign total_wide = {1'b0, total_reg} + (mpsm_pkg::TOTAL_W+1)'(count_reg);
    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign let_ok = req.letter < mpsm_pkg::LET_W'(mpsm_pkg::ALPHABET);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpsm_pkg::S_CLR:
            begin
                if (clr_idx_reg == {NW{1'b1}})
                begin
                    state_next = clr_rsp_reg ? mpsm_pkg::S_DONE : mpsm_pkg::S_IDLE;
                end
            end
            mpsm_pkg::S_IDLE:
            begin
                if (take)
                begin
                    case (req.req_type)
                        mpsm_pkg::REQ_CLEAR:  state_next = mpsm_pkg::S_CLR;
                        mpsm_pkg::REQ_INSERT:
                            state_next = (!built_reg && let_ok) ? mpsm_pkg::S_INS
                                                                : mpsm_pkg::S_DONE;
                        mpsm_pkg::REQ_END:
                            state_next = built_reg ? mpsm_pkg::S_DONE : mpsm_pkg::S_ENDW;
                        mpsm_pkg::REQ_BUILD:
                            state_next = built_reg ? mpsm_pkg::S_DONE : mpsm_pkg::S_BQ;
                        mpsm_pkg::REQ_SCAN:
                            state_next = let_ok ? mpsm_pkg::S_SC1 : mpsm_pkg::S_DONE;
                        default:              state_next = mpsm_pkg::S_DONE;
                    endcase
                end
            end
            mpsm_pkg::S_INS:  state_next = mpsm_pkg::S_DONE;
            mpsm_pkg::S_ENDW: state_next = mpsm_pkg::S_DONE;
            mpsm_pkg::S_SC1:  state_next = mpsm_pkg::S_SC2;
            mpsm_pkg::S_SC2:
                state_next = (o_rdata == '0) ? mpsm_pkg::S_SCF : mpsm_pkg::S_SC3;
            mpsm_pkg::S_SC3:  state_next = mpsm_pkg::S_SC2;
            mpsm_pkg::S_SCF:  state_next = mpsm_pkg::S_DONE;
            mpsm_pkg::S_BQ:
                state_next = (head_reg == tail_reg) ? mpsm_pkg::S_DONE : mpsm_pkg::S_BN;
            mpsm_pkg::S_BN:   state_next = mpsm_pkg::S_BF;
            mpsm_pkg::S_BF:   state_next = mpsm_pkg::S_BL;
            mpsm_pkg::S_BL:
            begin
                if (child != '0)
                begin
                    state_next = mpsm_pkg::S_BC;
                end
                else if (let_reg == mpsm_pkg::LET_W'(mpsm_pkg::ALPHABET - 1))
                begin
                    state_next = mpsm_pkg::S_BW;
                end
            end
            mpsm_pkg::S_BC:
                state_next = (let_reg == mpsm_pkg::LET_W'(mpsm_pkg::ALPHABET - 1))
                             ? mpsm_pkg::S_BW : mpsm_pkg::S_BL;
            mpsm_pkg::S_BW:   state_next = mpsm_pkg::S_BQ;
            mpsm_pkg::S_DONE:
                state_next = rsp_free ? mpsm_pkg::S_IDLE : mpsm_pkg::S_DONE;
            default:          state_next = mpsm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next = req_reg;
        ins_cur_next = ins_cur_reg;
        scan_cur_next = scan_cur_reg;
        used_next = used_reg;
        total_next = total_reg;
        built_next = built_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        clr_idx_next = clr_idx_reg;
        clr_rsp_next = clr_rsp_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        node_next = node_reg;
        row_next = row_reg;
        let_next = let_reg;
        j_next = j_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        g_we = 1'b0; g_re = 1'b0; g_waddr = '0; g_raddr = '0; g_wdata = '0;
        f_we = 1'b0; f_re = 1'b0; f_waddr = '0; f_raddr = '0; f_wdata = '0;
        o_we = 1'b0; o_re = 1'b0; o_waddr = '0; o_raddr = '0; o_wdata = '0;
        e_we = 1'b0; e_re = 1'b0; e_waddr = '0; e_raddr = '0; e_wdata = '0;
        q_we = 1'b0; q_re = 1'b0; q_waddr = '0; q_raddr = '0; q_wdata = '0;
        case (state_reg)
            mpsm_pkg::S_CLR:
            begin
                g_we = 1'b1;
                g_waddr = clr_idx_reg;
                for (int i = 0; i < mpsm_pkg::ALPHABET; i++)
                begin
                    g_wdata[i] = (clr_idx_reg == '0) ? mpsm_pkg::ROOT : '0;
                end
                f_we = 1'b1; f_waddr = clr_idx_reg;
                o_we = 1'b1; o_waddr = clr_idx_reg;
                e_we = 1'b1; e_waddr = clr_idx_reg;
                clr_idx_next = clr_idx_reg + NW'(1);
            end
            mpsm_pkg::S_IDLE:
            begin
                if (take)
                begin
                    req_next = req;
                    count_next = '0;
                    ovf_next = 1'b0;
                    case (req.req_type)
                        mpsm_pkg::REQ_CLEAR:
                        begin
                            ins_cur_next = mpsm_pkg::ROOT;
                            scan_cur_next = mpsm_pkg::ROOT;
                            used_next = mpsm_pkg::USED_W'(2);
                            total_next = '0;
                            built_next = 1'b0;
                            clr_idx_next = '0;
                            clr_rsp_next = 1'b1;
                        end
                        mpsm_pkg::REQ_INSERT:
                        begin
                            g_re = 1'b1;
                            g_raddr = ins_cur_reg;
                        end
                        mpsm_pkg::REQ_END:
                        begin
                            e_re = 1'b1;
                            e_raddr = ins_cur_reg;
                        end
                        mpsm_pkg::REQ_BUILD:
                        begin
                            q_we = 1'b1;
                            q_waddr = '0;
                            q_wdata = mpsm_pkg::ROOT;
                            head_next = '0;
                            tail_next = (NW+1)'(1);
                        end
                        mpsm_pkg::REQ_SCAN:
                        begin
                            scan_cur_next = scan_eff;
                            if (req.text_start)
                            begin
                                total_next = '0;
                            end
                            g_re = 1'b1;
                            g_raddr = scan_eff;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mpsm_pkg::S_INS:
            begin
                if (g_rdata[req_reg.letter] != '0)
                begin
                    ins_cur_next = g_rdata[req_reg.letter];
                end
                else if (used_reg < mpsm_pkg::USED_W'(mpsm_pkg::NODES))
                begin
                    g_we = 1'b1;
                    g_waddr = ins_cur_reg;
                    g_wdata = g_rdata;
                    g_wdata[req_reg.letter] = used_reg[NW-1:0];
                    ins_cur_next = used_reg[NW-1:0];
                    used_next = used_reg + mpsm_pkg::USED_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            mpsm_pkg::S_ENDW:
            begin
                e_we = 1'b1;
                e_waddr = ins_cur_reg;
                e_wdata = (e_rdata == {CW{1'b1}}) ? e_rdata : e_rdata + CW'(1);
                ins_cur_next = mpsm_pkg::ROOT;
            end
            mpsm_pkg::S_SC1:
            begin
                scan_cur_next = g_rdata[req_reg.letter];
                o_re = 1'b1;
                o_raddr = g_rdata[req_reg.letter];
            end
            mpsm_pkg::S_SC2:
            begin
                j_next = o_rdata;
                e_re = 1'b1; e_raddr = o_rdata;
                f_re = 1'b1; f_raddr = o_rdata;
            end
            mpsm_pkg::S_SC3:
            begin
                count_next = sum_wide[mpsm_pkg::MATCH_W] ? {mpsm_pkg::MATCH_W{1'b1}}
                                                         : sum_wide[mpsm_pkg::MATCH_W-1:0];
                if (consume_reg)
                begin
                    e_we = 1'b1;
                    e_waddr = j_reg;
                end
                o_re = 1'b1;
                o_raddr = f_rdata;
            end
            mpsm_pkg::S_SCF:
            begin
                total_next = total_wide[mpsm_pkg::TOTAL_W] ? {mpsm_pkg::TOTAL_W{1'b1}}
                                                           : total_wide[mpsm_pkg::TOTAL_W-1:0];
            end
            mpsm_pkg::S_BQ:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                end
                else
                begin
                    q_re = 1'b1;
                    q_raddr = head_reg[NW-1:0];
                    head_next = head_reg + (NW+1)'(1);
                end
            end
            mpsm_pkg::S_BN:
            begin
                node_next = q_rdata;
                g_re = 1'b1; g_raddr = q_rdata;
                f_re = 1'b1; f_raddr = q_rdata;
            end
            mpsm_pkg::S_BF:
            begin
                row_next = g_rdata;
                g_re = 1'b1;
                g_raddr = f_rdata;
                let_next = '0;
            end
            mpsm_pkg::S_BL:
            begin
                if (child != '0)
                begin
                    e_re = 1'b1; e_raddr = child;
                    o_re = 1'b1; o_raddr = g_rdata[let_reg];
                end
                else
                begin
                    row_next[let_reg] = g_rdata[let_reg];
                    let_next = let_reg + mpsm_pkg::LET_W'(1);
                end
            end
            mpsm_pkg::S_BC:
            begin
                f_we = 1'b1; f_waddr = child; f_wdata = g_rdata[let_reg];
                o_we = 1'b1; o_waddr = child;
                o_wdata = (e_rdata != '0) ? child : o_rdata;
                if (tail_reg < (NW+1)'(mpsm_pkg::NODES))
                begin
                    q_we = 1'b1;
                    q_waddr = tail_reg[NW-1:0];
                    q_wdata = child;
                    tail_next = tail_reg + (NW+1)'(1);
                end
                let_next = let_reg + mpsm_pkg::LET_W'(1);
            end
            mpsm_pkg::S_BW:
            begin
                g_we = 1'b1;
                g_waddr = node_reg;
                g_wdata = row_reg;
            end
            mpsm_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    clr_rsp_next = 1'b0;
                    rsp_valid_next = 1'b1;
                    rsp_next.match_count = count_reg;
                    rsp_next.running_total = total_reg;
                    rsp_next.clean = (count_reg == '0);
                    rsp_next.node_overflow = ovf_reg;
                    rsp_next.current_node =
                        (req_reg.req_type == mpsm_pkg::REQ_INSERT ||
                         req_reg.req_type == mpsm_pkg::REQ_END) ? ins_cur_reg : scan_cur_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            goto_mem[g_waddr] <= g_wdata;
        end
        if (g_re)
        begin
            g_rdata <= goto_mem[g_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[f_waddr] <= f_wdata;
        end
        if (f_re)
        begin
            f_rdata <= fail_mem[f_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            out_mem[o_waddr] <= o_wdata;
        end
        if (o_re)
        begin
            o_rdata <= out_mem[o_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            end_mem[e_waddr] <= e_wdata;
        end
        if (e_re)
        begin
            e_rdata <= end_mem[e_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rdata <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        count_reg <= count_next;
        ovf_reg <= ovf_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        node_reg <= node_next;
        row_reg <= row_next;
        let_reg <= let_next;
        j_reg <= j_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpsm_pkg::S_CLR;
            ins_cur_reg <= mpsm_pkg::ROOT;
            scan_cur_reg <= mpsm_pkg::ROOT;
            used_reg <= mpsm_pkg::USED_W'(2);
            total_reg <= '0;
            built_reg <= 1'b0;
            consume_reg <= 1'b1;
            clr_idx_reg <= '0;
            clr_rsp_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ins_cur_reg <= ins_cur_next;
            scan_cur_reg <= scan_cur_next;
            used_reg <= used_next;
            total_reg <= total_next;
            built_reg <= built_next;
            if (cfg_valid && cfg_ready)
            begin
                consume_reg <= cfg_data;
            end
            clr_idx_reg <= clr_idx_next;
            clr_rsp_reg <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: src/mpsm_checker.sv
module mpsm_assertions (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input mpsm_pkg::rsp_t rsp
);

    // A stalled response transaction keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // The clean flag is set exactly when nothing was counted.
    a_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.clean == (rsp.match_count == '0)))
        else $error("clean flag disagrees with match count");

    // One request transaction is worked on at a time.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind multi_pattern_string_matcher_unit mpsm_assertions u_mpsm_assertions (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
);
